// ===== design/modbus_rtu_master_register_access_defines.svh =====
// Assertion helpers shared by the RTL of the Modbus RTU master.
`ifndef MODBUS_RTU_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define MODBUS_RTU_MASTER_REGISTER_ACCESS_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MRRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MRRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mrra_pkg.sv =====
package mrra_pkg;

    // Request opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_BYTE  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Read completion status
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd2;

    localparam logic [15:0] VALUE_TIMEOUT = 16'hFFFF;
    localparam logic [15:0] VALUE_BAD_HDR = 16'hFFFE;

    // Configuration register indexes
    localparam logic CFG_SLAVE_ID = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam logic [7:0]  SLAVE_ID_RESET = 8'h01;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd150;

    // Frame layout
    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] READ_COUNT        = 16'h0001;
    localparam int          FRAME_DATA_BYTES  = 6;
    localparam int          FRAME_BYTES       = 8;
    localparam int          FRAME_IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Response buffer
    localparam int RESPONSE_BYTES = 7;
    localparam int RX_IDX_W       = $clog2(RESPONSE_BYTES);
    localparam int RX_COUNT_W     = $clog2(RESPONSE_BYTES + 1);

    localparam int HDR_ID_POS   = 0;
    localparam int HDR_FUNC_POS = 1;
    localparam int VALUE_HI_POS = 3;
    localparam int VALUE_LO_POS = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] reg_addr;
        logic [15:0] reg_value;
        logic [7:0]  rx_byte;
    } mrra_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] read_value;
        logic [1:0]  read_status;
    } mrra_out_t;

    // Fold one byte into a reflected CRC-16.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== design/modbus_rtu_master_register_access.sv =====
// Modbus RTU master for single-register access to one slave. A write (op 0) or
// read (op 1) request streams an 8-byte frame (slave id, function 06 or 03,
// address, value or count 1, CRC-16 low then high) at one byte per cycle while
// the output is not stalled, tx_last on the eighth; the input is held off while
// a frame drains. The CRC is folded one byte per cycle as the frame shifts out,
// stalling with the output. Received bytes (op 2) and millisecond ticks (op 3)
// are taken one per cycle while no frame drains and the output is not stalled,
// and give at most one result: the register value or a bad-header status once
// seven response bytes are in, or a timeout once the ticks reach timeout_ms.
// Bytes and ticks are dropped when no read is pending. The response CRC is
// not checked. Registers: index 0 slave_id (reset 1), index 1 timeout_ms
// (reset 150); write them only while the block is idle.
`include "modbus_rtu_master_register_access_defines.svh"

module modbus_rtu_master_register_access (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  mrra_pkg::mrra_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mrra_pkg::mrra_out_t m_data
);
    import mrra_pkg::*;

    // Configuration
    logic [7:0]  slave_id_reg, slave_id_next;
    logic [15:0] timeout_reg, timeout_next;

    // Frame serializer
    logic                   busy_reg, busy_next;
    logic [FRAME_IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]             frame_reg [FRAME_DATA_BYTES];
    logic [7:0]             frame_next [FRAME_DATA_BYTES];
    logic [15:0]            crc_reg, crc_next;

    // Response tracking
    logic                  waiting_reg, waiting_next;
    logic [RX_COUNT_W-1:0] rx_count_reg, rx_count_next;
    logic [15:0]           elapsed_reg, elapsed_next;
    logic [7:0]            rx_buf_reg [RESPONSE_BYTES];
    logic                  rx_we;

    // Output register
    logic      m_valid_reg, m_valid_next;
    mrra_out_t m_data_reg, m_data_next;

    logic        slot_free;
    logic        s_accept;
    logic        emit;
    logic [7:0]  emit_byte;
    logic [15:0] elapsed_sat;
    logic        hdr_ok;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = !busy_reg && slot_free;
    assign s_accept  = s_valid && s_ready;
    assign emit      = busy_reg && slot_free;

    assign elapsed_sat = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign hdr_ok = (rx_buf_reg[HDR_ID_POS] == slave_id_reg) &&
                    (rx_buf_reg[HDR_FUNC_POS] == FUNC_READ_HOLDING);

    // Pick the frame byte at the head of the serializer
    always_comb begin
        if (idx_reg < FRAME_IDX_W'(FRAME_DATA_BYTES)) begin
            emit_byte = frame_reg[0];
        end else if (idx_reg == FRAME_IDX_W'(FRAME_DATA_BYTES)) begin
            emit_byte = crc_reg[7:0];
        end else begin
            emit_byte = crc_reg[15:8];
        end
    end

    always_comb begin
        slave_id_next = slave_id_reg;
        timeout_next  = timeout_reg;
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        frame_next    = frame_reg;
        crc_next      = crc_reg;
        waiting_next  = waiting_reg;
        rx_count_next = rx_count_reg;
        elapsed_next  = elapsed_reg;
        rx_we         = 1'b0;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        // Apply configuration writes
        if (cfg_we) begin
            case (cfg_index)
                CFG_SLAVE_ID: slave_id_next = cfg_wdata[7:0];
                CFG_TIMEOUT:  timeout_next  = cfg_wdata;
                default: ;
            endcase
        end

        // Advance the serializer: shift data bytes through the CRC, then send the CRC
        if (emit) begin
            if (idx_reg < FRAME_IDX_W'(FRAME_DATA_BYTES)) begin
                crc_next = crc16_byte(crc_reg, frame_reg[0]);
                for (int i = 0; i < FRAME_DATA_BYTES - 1; i++) begin
                    frame_next[i] = frame_reg[i + 1];
                end
            end
            idx_next                = idx_reg + FRAME_IDX_W'(1);
            busy_next               = (idx_reg != FRAME_IDX_W'(FRAME_BYTES - 1));
            m_valid_next            = 1'b1;
            m_data_next.kind        = KIND_TX;
            m_data_next.tx_byte     = emit_byte;
            m_data_next.tx_last     = (idx_reg == FRAME_IDX_W'(FRAME_BYTES - 1));
            m_data_next.read_value  = 16'h0000;
            m_data_next.read_status = STATUS_OK;
        end

        // Handle an accepted request
        if (s_accept) begin
            case (s_data.op)
                OP_WRITE, OP_READ: begin
                    busy_next     = 1'b1;
                    idx_next      = '0;
                    crc_next      = CRC_INIT;
                    frame_next[0] = slave_id_reg;
                    frame_next[2] = s_data.reg_addr[15:8];
                    frame_next[3] = s_data.reg_addr[7:0];
                    if (s_data.op == OP_WRITE) begin
                        frame_next[1] = FUNC_WRITE_SINGLE;
                        frame_next[4] = s_data.reg_value[15:8];
                        frame_next[5] = s_data.reg_value[7:0];
                    end else begin
                        frame_next[1] = FUNC_READ_HOLDING;
                        frame_next[4] = READ_COUNT[15:8];
                        frame_next[5] = READ_COUNT[7:0];
                        rx_count_next = '0;
                        waiting_next  = 1'b1;
                        elapsed_next  = 16'h0000;
                    end
                end
                OP_BYTE: begin
                    if (waiting_reg) begin
                        rx_we         = 1'b1;
                        rx_count_next = rx_count_reg + RX_COUNT_W'(1);
                        if (rx_count_reg == RX_COUNT_W'(RESPONSE_BYTES - 1)) begin
                            waiting_next            = 1'b0;
                            m_valid_next            = 1'b1;
                            m_data_next.kind        = KIND_READ;
                            m_data_next.tx_byte     = 8'h00;
                            m_data_next.tx_last     = 1'b0;
                            if (hdr_ok) begin
                                m_data_next.read_value  = {rx_buf_reg[VALUE_HI_POS],
                                                           rx_buf_reg[VALUE_LO_POS]};
                                m_data_next.read_status = STATUS_OK;
                            end else begin
                                m_data_next.read_value  = VALUE_BAD_HDR;
                                m_data_next.read_status = STATUS_BAD_HDR;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (waiting_reg) begin
                        elapsed_next = elapsed_sat;
                        if (elapsed_sat >= timeout_reg) begin
                            waiting_next            = 1'b0;
                            m_valid_next            = 1'b1;
                            m_data_next.kind        = KIND_READ;
                            m_data_next.tx_byte     = 8'h00;
                            m_data_next.tx_last     = 1'b0;
                            m_data_next.read_value  = VALUE_TIMEOUT;
                            m_data_next.read_status = STATUS_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_id_reg <= SLAVE_ID_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            waiting_reg  <= 1'b0;
            rx_count_reg <= '0;
            elapsed_reg  <= 16'h0000;
            m_valid_reg  <= 1'b0;
        end else begin
            slave_id_reg <= slave_id_next;
            timeout_reg  <= timeout_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            waiting_reg  <= waiting_next;
            rx_count_reg <= rx_count_next;
            elapsed_reg  <= elapsed_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload: frame bytes, CRC, response buffer, result
    always_ff @(posedge aclk) begin
        frame_reg  <= frame_next;
        crc_reg    <= crc_next;
        m_data_reg <= m_data_next;
        if (rx_we) begin
            rx_buf_reg[rx_count_reg[RX_IDX_W-1:0]] <= s_data.rx_byte;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MRRA_ASSERT_NOW(a_busy_blocks_input, busy_reg, !s_ready, "request taken while a frame drains")
    `MRRA_ASSERT_NOW(a_last_ends_frame, m_valid_reg && !m_data_reg.kind && m_data_reg.tx_last, !busy_reg, "serializer still busy after last frame byte")
    `MRRA_ASSERT_NEXT(a_read_arms_wait, s_accept && (s_data.op == OP_READ), waiting_reg && busy_reg && (rx_count_reg == '0), "read request did not arm the response wait")

endmodule

// ===== tb/sv/tb_modbus_rtu_master_register_access.sv =====
module tb_modbus_rtu_master_register_access;
    import mrra_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 12;
    localparam int RANDOM_ITEMS = 400;
    localparam int MAX_REPORTS  = 10;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    mrra_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    mrra_out_t   m_data;

    // Master state as predicted from accepted requests
    logic [7:0]  cur_slave_id;
    logic [15:0] cur_timeout;
    logic [7:0]  rx_buf [RESPONSE_BYTES];
    int          rx_fill;
    bit          awaiting;
    logic [15:0] ms_count;

    mrra_out_t   pending_out [$];
    mrra_out_t   want;
    int          mismatches;
    int          effective_items;
    int          cycle_count;
    bit          idling;
    int unsigned sink_hold;

    modbus_rtu_master_register_access DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #10 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned src_gap();
        if (!idling || $urandom_range(0, 99) < 65) return 0;
        return pick_gap();
    endfunction

    // Stall the result side at random
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 99) < 15) begin
            sink_hold = pick_gap() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Queue the eight bytes of one frame, CRC low byte first
    function automatic void push_frame(input logic [7:0] func, input logic [15:0] addr,
                                       input logic [15:0] val);
        logic [7:0]  f [FRAME_BYTES];
        logic [15:0] crc;
        mrra_out_t   r;
        f[0] = cur_slave_id;
        f[1] = func;
        f[2] = addr[15:8];
        f[3] = addr[7:0];
        f[4] = val[15:8];
        f[5] = val[7:0];
        crc = CRC_INIT;
        for (int k = 0; k < FRAME_DATA_BYTES; k++) begin
            crc = crc ^ {8'h00, f[k]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        f[6] = crc[7:0];
        f[7] = crc[15:8];
        for (int k = 0; k < FRAME_BYTES; k++) begin
            r = '0;
            r.kind = KIND_TX;
            r.tx_byte = f[k];
            r.tx_last = (k == FRAME_BYTES - 1);
            pending_out.push_back(r);
        end
    endfunction

    function automatic void push_read_done(input logic [15:0] val, input logic [1:0] status);
        mrra_out_t r;
        r = '0;
        r.kind = KIND_READ;
        r.read_value = val;
        r.read_status = status;
        pending_out.push_back(r);
    endfunction

    // Advance the master by one request; returns 0 when the request is dropped
    function automatic bit master_step(input mrra_in_t req);
        case (req.op)
            OP_WRITE: begin
                push_frame(FUNC_WRITE_SINGLE, req.reg_addr, req.reg_value);
            end
            OP_READ: begin
                rx_fill = 0;
                awaiting = 1'b1;
                ms_count = '0;
                push_frame(FUNC_READ_HOLDING, req.reg_addr, READ_COUNT);
            end
            OP_BYTE: begin
                if (!awaiting) return 1'b0;
                rx_buf[rx_fill] = req.rx_byte;
                rx_fill++;
                if (rx_fill == RESPONSE_BYTES) begin
                    awaiting = 1'b0;
                    if (rx_buf[HDR_ID_POS] != cur_slave_id
                            || rx_buf[HDR_FUNC_POS] != FUNC_READ_HOLDING) begin
                        push_read_done(VALUE_BAD_HDR, STATUS_BAD_HDR);
                    end else begin
                        push_read_done({rx_buf[VALUE_HI_POS], rx_buf[VALUE_LO_POS]}, STATUS_OK);
                    end
                end
            end
            default: begin
                if (!awaiting) return 1'b0;
                if (ms_count != 16'hFFFF) ms_count++;
                if (ms_count >= cur_timeout) begin
                    awaiting = 1'b0;
                    push_read_done(VALUE_TIMEOUT, STATUS_TIMEOUT);
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void log_miss(input string what, input mrra_out_t exp_r,
                                     input mrra_out_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s: expected kind=%0d tx=%02h last=%0d value=%04h status=%0d",
                     what, exp_r.kind, exp_r.tx_byte, exp_r.tx_last, exp_r.read_value,
                     exp_r.read_status);
            $display("    got kind=%0d tx=%02h last=%0d value=%04h status=%0d",
                     got.kind, got.tx_byte, got.tx_last, got.read_value, got.read_status);
        end
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_out.size() == 0) begin
                log_miss("unexpected result", '0, m_data);
            end else begin
                want = pending_out.pop_front();
                if (want.kind !== m_data.kind || want.tx_byte !== m_data.tx_byte
                        || want.tx_last !== m_data.tx_last
                        || want.read_value !== m_data.read_value
                        || want.read_status !== m_data.read_status) begin
                    log_miss("result mismatch", want, m_data);
                end
            end
        end
    end

    function automatic mrra_in_t rand_request(input logic [1:0] op);
        mrra_in_t req;
        req.op = op;
        req.reg_addr = 16'($urandom_range(0, 16'hFFFF));
        req.reg_value = 16'($urandom_range(0, 16'hFFFF));
        req.rx_byte = 8'($urandom_range(0, 8'hFF));
        return req;
    endfunction

    // Present one request and hold it until taken
    task automatic send_request(input mrra_in_t req);
        int unsigned gap;
        gap = src_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (master_step(req)) effective_items++;
    endtask

    task automatic send_byte(input logic [7:0] value);
        mrra_in_t req;
        req = rand_request(OP_BYTE);
        req.rx_byte = value;
        send_request(req);
    endtask

    task automatic send_frame_request(input logic [1:0] op, input logic [15:0] addr,
                                      input logic [15:0] val);
        mrra_in_t req;
        req = rand_request(op);
        req.reg_addr = addr;
        req.reg_value = val;
        send_request(req);
    endtask

    // Drain all results, then let the block settle
    task automatic wait_quiet();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_out.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_SLAVE_ID) cur_slave_id = val[7:0];
        else cur_timeout = val;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Finish any open read with bytes
    task automatic close_pending();
        while (awaiting) send_byte(8'($urandom_range(0, 8'hFF)));
    endtask

    task automatic test_idle_drops();
        send_byte(8'hFF);
        send_request(rand_request(OP_TICK));
    endtask

    task automatic test_write_frames();
        send_frame_request(OP_WRITE, 16'h0000, 16'h0000);
        send_frame_request(OP_WRITE, 16'hFFFF, 16'hFFFF);
    endtask

    // Read completes even with a write sent while it waits
    task automatic test_read_with_write();
        send_frame_request(OP_READ, 16'hFFFF, 16'h0000);
        send_byte(cur_slave_id);
        send_byte(FUNC_READ_HOLDING);
        send_byte(8'h02);
        send_byte(8'hAB);
        send_byte(8'hCD);
        send_frame_request(OP_WRITE, 16'h5A5A, 16'hA5A5);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Second read drops the first wait; reply carries a wrong function code
    task automatic test_read_restart();
        send_frame_request(OP_READ, 16'h0000, 16'hFFFF);
        send_byte(cur_slave_id);
        send_byte(FUNC_READ_HOLDING);
        send_frame_request(OP_READ, 16'h1357, 16'h0000);
        send_byte(cur_slave_id);
        send_byte(FUNC_WRITE_SINGLE);
        send_byte(8'h02);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    task automatic test_timeout_limits();
        wait_quiet();
        write_register(CFG_TIMEOUT, 16'd0);
        send_frame_request(OP_READ, 16'h0042, 16'h0000);
        send_request(rand_request(OP_TICK));
        wait_quiet();
        write_register(CFG_TIMEOUT, 16'd1);
        send_frame_request(OP_READ, 16'h0043, 16'h0000);
        send_request(rand_request(OP_TICK));
        wait_quiet();
        // full-range timeout: a few ticks must not end the wait
        write_register(CFG_TIMEOUT, 16'hFFFF);
        send_frame_request(OP_READ, 16'h0044, 16'h0000);
        repeat (8) send_request(rand_request(OP_TICK));
        close_pending();
    endtask

    // Mostly well-formed reply with random content, ticks and writes sprinkled in; may end in a timeout
    task automatic read_exchange();
        bit          to_timeout;
        int          stop_at;
        logic [7:0]  b;
        to_timeout = (cur_timeout <= 40) && ($urandom_range(0, 3) == 0);
        stop_at = to_timeout ? $urandom_range(0, RESPONSE_BYTES - 1) : RESPONSE_BYTES;
        send_request(rand_request(OP_READ));
        for (int k = 0; k < stop_at; k++) begin
            if ($urandom_range(0, 99) < 5) send_request(rand_request(OP_WRITE));
            while ($urandom_range(0, 3) == 0 && int'(ms_count) + 1 < int'(cur_timeout))
                send_request(rand_request(OP_TICK));
            b = 8'($urandom_range(0, 8'hFF));
            if (k == HDR_ID_POS && $urandom_range(0, 99) < 90) b = cur_slave_id;
            if (k == HDR_FUNC_POS && $urandom_range(0, 99) < 90) b = FUNC_READ_HOLDING;
            send_byte(b);
        end
        if (to_timeout) begin
            while (awaiting) send_request(rand_request(OP_TICK));
        end
    endtask

    task automatic test_random_traffic();
        int base;
        int phase;
        int r;
        base = effective_items;
        phase = 0;
        while (effective_items - base < RANDOM_ITEMS) begin
            wait_quiet();
            case (phase)
                0: begin
                    write_register(CFG_SLAVE_ID, 16'h0000);
                    write_register(CFG_TIMEOUT, 16'd1);
                end
                1: begin
                    write_register(CFG_SLAVE_ID, 16'h00FF);
                    write_register(CFG_TIMEOUT, 16'hFFFF);
                end
                default: begin
                    write_register(CFG_SLAVE_ID, 16'($urandom_range(0, 8'hFF)));
                    write_register(CFG_TIMEOUT,
                                   16'(($urandom_range(0, 99) < 15) ? 0
                                                                    : $urandom_range(2, 16)));
                end
            endcase
            idling = (phase % 3 != 2);
            repeat (15) begin
                r = $urandom_range(0, 99);
                if (r < 65) read_exchange();
                else if (r < 80) send_request(rand_request(OP_WRITE));
                else send_request(rand_request(2'($urandom_range(0, 3))));
            end
            close_pending();
            phase++;
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SLAVE_ID;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        sink_hold = 0;
        idling = 1'b1;
        mismatches = 0;
        effective_items = 0;
        cycle_count = 0;
        cur_slave_id = SLAVE_ID_RESET;
        cur_timeout = TIMEOUT_RESET;
        rx_fill = 0;
        awaiting = 1'b0;
        ms_count = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_drops();
        test_write_frames();
        test_read_with_write();
        test_read_restart();
        test_timeout_limits();
        test_random_traffic();

        wait_quiet();
        if (mismatches == 0 && pending_out.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mrra_pkg.sv
design/modbus_rtu_master_register_access.sv
tb/sv/tb_modbus_rtu_master_register_access.sv
